FILE: hw/rtl/ifp_pkg.sv
package ifp_pkg;

  localparam int FRAME_BYTES_DEF   = 32;
  localparam int CHANNEL_COUNT_DEF = 14;

  localparam logic [7:0]  HDR_FIRST  = 8'h20;
  localparam logic [7:0]  HDR_SECOND = 8'h40;
  localparam logic [15:0] SUM_START  = 16'hFFFF;

  localparam logic [15:0] LIMIT_HIGH     = 16'd2000;
  localparam logic [15:0] LIMIT_LOW      = 16'd900;
  localparam logic [15:0] LIMIT_LOW_THR  = 16'd1000;
  localparam logic [15:0] FALLBACK_STICK = 16'd1500;
  localparam logic [15:0] FALLBACK_LOW   = 16'd1000;

  localparam logic [7:0] CH_THROTTLE  = 8'd2;
  localparam logic [7:0] CH_AUX       = 8'd4;
  localparam logic [7:0] CH_LAST_RULE = 8'd4;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_FETCH,
    ST_CLAMP,
    ST_SEND
  } state_t;

  typedef enum logic [1:0] {
    RULE_PASS,
    RULE_STICK,
    RULE_THROTTLE,
    RULE_AUX
  } rule_t;

endpackage

FILE: hw/rtl/ifp_if.sv
interface ifp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ifp_chan_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel_index;
  logic [15:0] raw_value;
  logic [15:0] conditioned_value;
  logic        last_channel;

  modport source (
    output valid, output channel_index, output raw_value,
    output conditioned_value, output last_channel, input ready
  );
  modport sink (
    input valid, input channel_index, input raw_value,
    input conditioned_value, input last_channel, output ready
  );
endinterface

FILE: hw/rtl/ifp_frame_store.sv
module ifp_frame_store
  import ifp_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  localparam int AW = $clog2(FRAME_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_lo,
  input  logic [AW-1:0] rd_addr_hi,
  output logic [7:0]    rd_data_lo,
  output logic [7:0]    rd_data_hi
);

  logic [7:0] mem [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_lo <= mem[rd_addr_lo];
      rd_data_hi <= mem[rd_addr_hi];
    end
  end

endmodule

FILE: hw/rtl/ifp_clamp.sv
module ifp_clamp
  import ifp_pkg::*;
(
  input  rule_t       rule,
  input  logic [15:0] value,
  output logic [15:0] result
);

  logic [15:0] lo_limit;
  logic [15:0] lo_value;

  always_comb begin
    case (rule)
      RULE_THROTTLE: begin
        lo_limit = LIMIT_LOW_THR;
        lo_value = FALLBACK_LOW;
      end
      RULE_AUX: begin
        lo_limit = LIMIT_LOW;
        lo_value = FALLBACK_LOW;
      end
      default: begin
        lo_limit = LIMIT_LOW;
        lo_value = FALLBACK_STICK;
      end
    endcase
  end

  always_comb begin
    if (rule == RULE_PASS) begin
      result = value;
    end else if (value < lo_limit) begin
      result = lo_value;
    end else if (value > LIMIT_HIGH) begin
      result = LIMIT_HIGH;
    end else begin
      result = value;
    end
  end

endmodule

FILE: hw/rtl/ibus_frame_parser_unit.sv
// receiver frame decoder, one serial byte per item on rx, one channel per item on chan
// rx carries rx_byte; bytes are taken one per cycle while the block hunts or fills a frame
// a frame is 0x20, 0x40, channel bytes, then a little-endian checksum in the last two bytes
// the checksum is 0xffff minus the 16-bit sum of all earlier bytes of the frame
// a bad second byte or a bad checksum drops the frame silently
// after a good frame, chan gives CHANNEL_COUNT items with index, raw and clamped value,
// last_channel set on the final one; rx is not ready during this burst
// each channel goes through the frame store read port and the clamp unit in turn:
// fetch, clamp, send; the next channel is fetched only once chan has taken this one
// after the last frame byte, fetch and clamp run before the first channel is valid
// a stall on chan holds the current item and its values until ready returns
// reset puts the block in hunt mode with byte position zero and the sum at 0xffff;
// the frame store is not cleared, every entry read is written in the same frame
module ibus_frame_parser_unit
  import ifp_pkg::*;
#(
  parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ifp_byte_if.sink    rx,
  ifp_chan_if.source  chan
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(CHANNEL_COUNT + 1);
  localparam int LW = $clog2(2 * CHANNEL_COUNT + FRAME_BYTES + 4);

  state_t state;
  state_t state_next;

  logic [AW-1:0] pos;
  logic [15:0]   sum;
  logic [7:0]    prev;
  logic [CW-1:0] chan_k;
  logic          in_range;

  logic [3:0]    out_index;
  logic [15:0]   out_raw;
  logic [15:0]   out_cond;
  logic          out_last;

  logic          rx_take;
  logic          chan_take;
  logic          rd_en;
  logic          frame_end;
  logic          sum_ok;
  logic          is_last;
  logic [LW-1:0] lo_addr;
  logic [LW-1:0] hi_addr;
  logic [7:0]    rd_lo;
  logic [7:0]    rd_hi;
  logic [7:0]    k_wide;
  logic [15:0]   raw_now;
  logic [15:0]   cond_now;
  rule_t         rule;

  assign rx_take   = rx.valid && rx.ready;
  assign chan_take = chan.valid && chan.ready;
  assign frame_end = (pos == AW'(FRAME_BYTES - 1));
  assign sum_ok    = ({rx.rx_byte, prev} == sum);
  assign is_last   = (chan_k == CW'(CHANNEL_COUNT - 1));

  assign lo_addr = (LW'(chan_k) << 1) + LW'(2);
  assign hi_addr = lo_addr + LW'(1);
  assign k_wide  = 8'(chan_k);

  always_comb begin
    if (k_wide == CH_THROTTLE) begin
      rule = RULE_THROTTLE;
    end else if (k_wide == CH_AUX) begin
      rule = RULE_AUX;
    end else if (k_wide <= CH_LAST_RULE) begin
      rule = RULE_STICK;
    end else begin
      rule = RULE_PASS;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_HUNT: begin
        if (rx_take && pos != '0 && frame_end && sum_ok) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (chan_take) begin
          state_next = out_last ? ST_HUNT : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  // outputs
  always_comb begin
    rx.ready   = 1'b0;
    chan.valid = 1'b0;
    rd_en      = 1'b0;
    case (state)
      ST_HUNT:  rx.ready = 1'b1;
      ST_FETCH: rd_en = 1'b1;
      ST_SEND:  chan.valid = 1'b1;
      default: begin
        rx.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  // frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sum <= SUM_START;
    end else if (rx_take) begin
      if (pos == '0) begin
        if (rx.rx_byte == HDR_FIRST) begin
          pos <= AW'(1);
          sum <= SUM_START - 16'(rx.rx_byte);
        end
      end else if (pos == AW'(1) && rx.rx_byte != HDR_SECOND) begin
        pos <= '0;
      end else if (frame_end) begin
        pos <= '0;
      end else begin
        pos <= pos + AW'(1);
        if (pos < AW'(FRAME_BYTES - 2)) begin
          sum <= sum - 16'(rx.rx_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      prev <= rx.rx_byte;
    end
  end

  // channel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_k <= '0;
    end else if (state == ST_HUNT) begin
      chan_k <= '0;
    end else if (chan_take) begin
      chan_k <= chan_k + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      in_range <= (hi_addr < LW'(FRAME_BYTES));
    end
  end

  ifp_frame_store #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_store (
    .clk        (clk),
    .wr_en      (rx_take && (pos != '0 || rx.rx_byte == HDR_FIRST)),
    .wr_addr    (pos),
    .wr_data    (rx.rx_byte),
    .rd_en      (rd_en),
    .rd_addr_lo (lo_addr[AW-1:0]),
    .rd_addr_hi (hi_addr[AW-1:0]),
    .rd_data_lo (rd_lo),
    .rd_data_hi (rd_hi)
  );

  assign raw_now = in_range ? {rd_hi, rd_lo} : 16'd0;

  ifp_clamp u_clamp (
    .rule   (rule),
    .value  (raw_now),
    .result (cond_now)
  );

  always_ff @(posedge clk) begin
    if (state == ST_CLAMP) begin
      out_index <= 4'(chan_k);
      out_raw   <= raw_now;
      out_cond  <= cond_now;
      out_last  <= is_last;
    end
  end

  assign chan.channel_index     = out_index;
  assign chan.raw_value         = out_raw;
  assign chan.conditioned_value = out_cond;
  assign chan.last_channel      = out_last;

endmodule

FILE: tb/ibus_frame_parser_unit_tb.sv
`timescale 1ns / 100ps

module ibus_frame_parser_unit_tb
  import ifp_pkg::*;
();

  localparam int FB          = FRAME_BYTES_DEF;
  localparam int NCH         = CHANNEL_COUNT_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [15:0] chan_set_t [NCH];

  typedef struct {
    logic [3:0]  idx;
    logic [15:0] raw;
    logic [15:0] cond;
    logic        last;
  } chan_item_t;

  logic clk;
  logic rst;

  ifp_byte_if rx_bus ();
  ifp_chan_if chan_bus ();

  ibus_frame_parser_unit DUT (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx_bus),
    .chan (chan_bus)
  );

  chan_item_t  chan_expect_q[$];
  int          error_count  = 0;
  int          cycle_count  = 0;
  int          hold_request = 0;
  bit          src_idle_on  = 1'b1;
  bit          sink_idle_on = 1'b1;

  // decoder state mirror
  int          frame_pos = 0;
  logic [15:0] frame_sum = SUM_START;
  logic [7:0]  frame_bytes [FB];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic rule_t channel_rule(int k);
    if (k == CH_THROTTLE) return RULE_THROTTLE;
    if (k == CH_AUX) return RULE_AUX;
    if (k > CH_LAST_RULE) return RULE_PASS;
    return RULE_STICK;
  endfunction

  function automatic logic [15:0] clamp_channel(int k, logic [15:0] v);
    logic [15:0] lo_thr;
    logic [15:0] lo_val;
    case (channel_rule(k))
      RULE_PASS: return v;
      RULE_THROTTLE: begin
        lo_thr = LIMIT_LOW_THR;
        lo_val = FALLBACK_LOW;
      end
      RULE_AUX: begin
        lo_thr = LIMIT_LOW;
        lo_val = FALLBACK_LOW;
      end
      default: begin
        lo_thr = LIMIT_LOW;
        lo_val = FALLBACK_STICK;
      end
    endcase
    if (v < lo_thr) return lo_val;
    if (v > LIMIT_HIGH) return LIMIT_HIGH;
    return v;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    chan_item_t item;
    int lo;
    if (frame_pos == 0) begin
      if (b != HDR_FIRST) return;
      frame_sum = SUM_START;
    end
    frame_bytes[frame_pos] = b;
    if (frame_pos < FB - 2) frame_sum = frame_sum - 16'(b);
    frame_pos++;
    if (frame_pos == 2 && b != HDR_SECOND) begin
      frame_pos = 0;
      return;
    end
    if (frame_pos < FB) return;
    frame_pos = 0;
    if ({frame_bytes[FB-1], frame_bytes[FB-2]} != frame_sum) return;
    for (int k = 0; k < NCH; k++) begin
      lo = 2 + 2 * k;
      item.idx  = 4'(k);
      item.raw  = (lo + 1 < FB) ? {frame_bytes[lo+1], frame_bytes[lo]} : 16'd0;
      item.cond = clamp_channel(k, item.raw);
      item.last = (k == NCH - 1);
      chan_expect_q.push_back(item);
    end
  endfunction

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : chan_check
    chan_item_t want;
    if (!rst && chan_bus.valid && chan_bus.ready) begin
      if (chan_expect_q.size() == 0) begin
        $display("%0t ns: unexpected channel item, expected none, got idx %0d raw %0d",
                 $time, chan_bus.channel_index, chan_bus.raw_value);
        error_count++;
      end else begin
        want = chan_expect_q.pop_front();
        check_field("channel_index", 16'(want.idx), 16'(chan_bus.channel_index));
        check_field("raw_value", want.raw, chan_bus.raw_value);
        check_field("conditioned_value", want.cond, chan_bus.conditioned_value);
        check_field("last_channel", 16'(want.last), 16'(chan_bus.last_channel));
      end
    end
  end

  initial begin : chan_receiver
    int n;
    chan_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        chan_bus.ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        chan_bus.ready = 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        chan_bus.ready = 1'b1;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      rx_bus.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    rx_bus.valid   = 1'b1;
    rx_bus.rx_byte = b;
    @(posedge clk);
    while (!rx_bus.ready) @(posedge clk);
    decode_byte(b);
    @(negedge clk);
  endtask

  task automatic send_frame(input chan_set_t ch, input bit bad_sum);
    logic [7:0]  fr [FB];
    logic [15:0] s;
    fr[0] = HDR_FIRST;
    fr[1] = HDR_SECOND;
    for (int i = 2; i < FB - 2; i++) fr[i] = 8'($urandom);
    for (int k = 0; k < NCH; k++) begin
      if (3 + 2 * k < FB - 2) begin
        fr[2 + 2 * k] = ch[k][7:0];
        fr[3 + 2 * k] = ch[k][15:8];
      end
    end
    s = SUM_START;
    for (int i = 0; i < FB - 2; i++) s = s - 16'(fr[i]);
    if (bad_sum) s = s ^ 16'($urandom_range(1, 65535));
    fr[FB-2] = s[7:0];
    fr[FB-1] = s[15:8];
    for (int i = 0; i < FB; i++) send_byte(fr[i]);
  endtask

  function automatic logic [15:0] rand_channel();
    int          pick;
    logic [15:0] base;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(850, 2050));
      2: begin
        pick = $urandom_range(0, 2);
        base = (pick == 0) ? LIMIT_LOW : (pick == 1) ? LIMIT_LOW_THR : LIMIT_HIGH;
        return base + 16'($urandom_range(0, 2)) - 16'd1;
      end
      default: return 16'($urandom_range(0, 1100));
    endcase
  endfunction

  function automatic chan_set_t rand_chan_set();
    chan_set_t ch;
    for (int k = 0; k < NCH; k++) ch[k] = rand_channel();
    return ch;
  endfunction

  task automatic send_broken_header();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == HDR_SECOND) b = ~b;
    send_byte(HDR_FIRST);
    send_byte($urandom_range(0, 1) ? HDR_FIRST : b);
  endtask

  task automatic test_hunt_and_header();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_SECOND);
    // second byte 0x20 drops both, then 0x40 is ignored while hunting
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(HDR_FIRST);
    send_byte(8'h7F);
  endtask

  task automatic test_clamp_bounds();
    chan_set_t ch;
    ch = '{0, 899, 999, 900, 899, 65535, 0, 16'h2040, 16'h4020, 16'h2020,
           1, 16'h8000, 16'h00FF, 16'hFF00};
    send_frame(ch, 1'b0);
    ch = '{2000, 2001, 1000, 65535, 900, 16'h5555, 16'hAAAA, 899, 2001, 1000,
           16'h0F0F, 16'hF0F0, 0, 65535};
    send_frame(ch, 1'b0);
    ch = '{901, 1500, 2001, 1999, 2001, 1001, 999, 2000, 2001, 900,
           899, 1000, 1500, 16'h7FFF};
    send_frame(ch, 1'b0);
  endtask

  task automatic test_bad_checksum();
    send_frame(rand_chan_set(), 1'b1);
    send_frame(rand_chan_set(), 1'b0);
  endtask

  task automatic test_backpressure();
    src_idle_on  = 1'b0;
    hold_request = 300;
    send_frame(rand_chan_set(), 1'b0);
    send_frame(rand_chan_set(), 1'b0);
    send_frame(rand_chan_set(), 1'b0);
  endtask

  task automatic test_random_frames();
    int kind;
    for (int f = 0; f < 3; f++) begin
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
      kind = $urandom_range(0, 9);
      if (kind == 0) send_frame(rand_chan_set(), 1'b1);
      else if (kind == 1) send_broken_header();
      else send_frame(rand_chan_set(), 1'b0);
    end
  endtask

  task automatic test_full_rate();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_frame(rand_chan_set(), 1'b0);
    send_frame(rand_chan_set(), 1'b0);
  endtask

  initial begin
    rst            = 1'b1;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_hunt_and_header();
    test_clamp_bounds();
    test_bad_checksum();
    test_backpressure();
    sink_idle_on = 1'b1;
    src_idle_on  = 1'b1;
    test_random_frames();
    test_full_rate();
    rx_bus.valid = 1'b0;
    while (chan_expect_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
